>>> design/fdtd_pkg.sv
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, constants and fixed-point helpers of the TM Yee grid update.
// ----------------------------------------------------------------------------
package fdtd_pkg;

   // Field formats
   localparam int VAL_W    = 16;
   localparam int FRAC_W   = 14;
   localparam int COORD_W  = 6;
   localparam int KIND_W   = 2;
   localparam int PROD_W   = 2 * VAL_W + 4;
   localparam int RND_W    = PROD_W - FRAC_W;

   // Default grid capacity
   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int SIZE_W     = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_FIRST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_END     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_FIRST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_END     = 3'd5;

   // Transaction kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  grid_width;
      logic [SIZE_W-1:0]  grid_height;
      logic [COORD_W-1:0] col_first;
      logic [SIZE_W-1:0]  col_end;
      logic [COORD_W-1:0] row_first;
      logic [SIZE_W-1:0]  row_end;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               in_grid;
      logic [VAL_W-1:0]   ez;
      logic [VAL_W-1:0]   hx;
      logic [VAL_W-1:0]   hy;
      logic [VAL_W-1:0]   ca;
      logic [VAL_W-1:0]   cb;
      logic [VAL_W-1:0]   da;
      logic [VAL_W-1:0]   db;
   } item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_READ_DATA,
      ST_STEP_INIT,
      ST_H_ADDR,
      ST_H_DOWN,
      ST_H_MUL,
      ST_H_WB,
      ST_E_INIT,
      ST_E_ADDR,
      ST_E_MUL,
      ST_E_WB,
      ST_DONE
   } back_state_type;

   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(2 ** (FRAC_W - 1));
   localparam logic signed [RND_W:0]    SAT_HI   = (RND_W + 1)'(2 ** (VAL_W - 1) - 1);
   localparam logic signed [RND_W:0]    SAT_LO   = (RND_W + 1)'(-(2 ** (VAL_W - 1)));

   // Round half up to FRAC_W fraction bits: add half an LSB, then floor
   function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] v;
      v = p + HALF_LSB;
      return v[PROD_W-1:FRAC_W];
   endfunction

   // Sum of two rounded products, saturated to the field width
   function automatic logic signed [VAL_W-1:0] combine(input logic signed [PROD_W-1:0] pa,
                                                       input logic signed [PROD_W-1:0] pb);
      logic signed [RND_W-1:0] ra;
      logic signed [RND_W-1:0] rb;
      logic signed [RND_W:0]   s;
      ra = round_q(pa);
      rb = round_q(pb);
      s  = ra + rb;
      if (s > SAT_HI) begin
         return VAL_W'(SAT_HI);
      end else if (s < SAT_LO) begin
         return VAL_W'(SAT_LO);
      end
      return s[VAL_W-1:0];
   endfunction

endpackage

>>> design/fdtd_tm_yee_update.sv
// ----------------------------------------------------------------------------
// fdtd_tm_yee_update
// 2D TM Yee grid engine: cell write/read and one-time-step field update.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    kind, col, row, ez..db values
//   rsp_      out        rsp_valid/rsp_ready    reply_kind, ez/hx/hy out
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// Write passes ST_WRITE, read ST_READ and ST_READ_DATA; both then the output register.
// Step: the sequencer sweeps the H-region cells, then the E-region cells,
// each cell through its read, multiply and write-back states.
// After reset a clearing pass over all MAX_COLS*MAX_ROWS cells zeroes Ez/Hx/Hy;
// req_ready stays low throughout it.
// A two-entry queue lets requests land while a response waits on rsp_ready.
// ----------------------------------------------------------------------------
module fdtd_tm_yee_update #(
   parameter int MAX_COLS = fdtd_pkg::GRID_COLS,
   parameter int MAX_ROWS = fdtd_pkg::GRID_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fdtd_pkg::KIND_W-1:0]          req_kind,
   input  logic [fdtd_pkg::COORD_W-1:0]         req_col,
   input  logic [fdtd_pkg::COORD_W-1:0]         req_row,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_ez_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_hx_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_hy_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_ca_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_cb_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_da_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0]    req_db_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fdtd_pkg::KIND_W-1:0]          rsp_reply_kind,
   output logic signed [fdtd_pkg::VAL_W-1:0]    rsp_ez_out,
   output logic signed [fdtd_pkg::VAL_W-1:0]    rsp_hx_out,
   output logic signed [fdtd_pkg::VAL_W-1:0]    rsp_hy_out,
   input  logic                                 csr_we,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fdtd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fdtd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid, q_pop, clearing;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata;
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata;
            CSR_COL_FIRST:   cfg_in.col_first   = csr_wdata[COORD_W-1:0];
            CSR_COL_END:     cfg_in.col_end     = csr_wdata;
            CSR_ROW_FIRST:   cfg_in.row_first   = csr_wdata[COORD_W-1:0];
            CSR_ROW_END:     cfg_in.row_end     = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= SIZE_W'(64);
         cfg_ff.grid_height <= SIZE_W'(64);
         cfg_ff.col_first   <= '0;
         cfg_ff.col_end     <= SIZE_W'(64);
         cfg_ff.row_first   <= '0;
         cfg_ff.row_end     <= SIZE_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fdtd_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_col   (req_col),
      .req_row   (req_row),
      .req_ez_in (req_ez_in),
      .req_hx_in (req_hx_in),
      .req_hy_in (req_hy_in),
      .req_ca_in (req_ca_in),
      .req_cb_in (req_cb_in),
      .req_da_in (req_da_in),
      .req_db_in (req_db_in),
      .clearing  (clearing),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   fdtd_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_ez_out     (rsp_ez_out),
      .rsp_hx_out     (rsp_hx_out),
      .rsp_hy_out     (rsp_hy_out)
   );

endmodule

>>> design/fdtd_front.sv
// ----------------------------------------------------------------------------
// fdtd_front
// Accepts request transactions, flags out-of-grid addresses and queues them.
// ----------------------------------------------------------------------------
module fdtd_front #(
   parameter int MAX_COLS = fdtd_pkg::GRID_COLS,
   parameter int MAX_ROWS = fdtd_pkg::GRID_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fdtd_pkg::KIND_W-1:0]   req_kind,
   input  logic [fdtd_pkg::COORD_W-1:0]  req_col,
   input  logic [fdtd_pkg::COORD_W-1:0]  req_row,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_ez_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_hx_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_hy_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_ca_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_cb_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_da_in,
   input  logic signed [fdtd_pkg::VAL_W-1:0] req_db_in,
   input  logic                          clearing,
   output logic                          q_valid,
   output fdtd_pkg::item_type            q_item,
   input  logic                          q_pop
);
   import fdtd_pkg::*;

   item_type   fifo_ff [2];
   item_type   new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Classify the incoming transaction
   always_comb begin
      new_item.kind    = req_kind;
      new_item.col     = req_col;
      new_item.row     = req_row;
      new_item.in_grid = (int'(req_col) < MAX_COLS) && (int'(req_row) < MAX_ROWS);
      new_item.ez      = req_ez_in;
      new_item.hx      = req_hx_in;
      new_item.hy      = req_hy_in;
      new_item.ca      = req_ca_in;
      new_item.cb      = req_cb_in;
      new_item.da      = req_da_in;
      new_item.db      = req_db_in;
   end

   // Two-entry queue toward the back end
   always_comb begin
      req_ready = (count_ff != 2'd2) && !clearing;
      push      = req_valid && req_ready;
      q_valid   = (count_ff != 2'd0);
      q_item    = fifo_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> design/fdtd_back.sv
// ----------------------------------------------------------------------------
// fdtd_back
// Grid stores, clearing pass, cell access and the H/E sweep sequencer.
// ----------------------------------------------------------------------------
module fdtd_back #(
   parameter int MAX_COLS = fdtd_pkg::GRID_COLS,
   parameter int MAX_ROWS = fdtd_pkg::GRID_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fdtd_pkg::cfg_type                 cfg,
   input  logic                              q_valid,
   input  fdtd_pkg::item_type                q_item,
   output logic                              q_pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fdtd_pkg::KIND_W-1:0]       rsp_reply_kind,
   output logic signed [fdtd_pkg::VAL_W-1:0] rsp_ez_out,
   output logic signed [fdtd_pkg::VAL_W-1:0] rsp_hx_out,
   output logic signed [fdtd_pkg::VAL_W-1:0] rsp_hy_out
);
   import fdtd_pkg::*;

   localparam int DEPTH   = MAX_COLS * MAX_ROWS;
   localparam int AW      = $clog2(DEPTH);
   localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   localparam int XW      = ($clog2(MAX_DIM) + 2 > 8) ? $clog2(MAX_DIM) + 2 : 8;

   // Stores
   logic signed [VAL_W-1:0] ez_mem [DEPTH];
   logic signed [VAL_W-1:0] hx_mem [DEPTH];
   logic signed [VAL_W-1:0] hy_mem [DEPTH];
   logic signed [VAL_W-1:0] ca_mem [DEPTH];
   logic signed [VAL_W-1:0] cb_mem [DEPTH];
   logic signed [VAL_W-1:0] da_mem [DEPTH];
   logic signed [VAL_W-1:0] db_mem [DEPTH];

   logic signed [VAL_W-1:0] ez_rd0_ff, ez_rd1_ff, hx_rd0_ff, hx_rd1_ff;
   logic signed [VAL_W-1:0] hy_rd0_ff, hy_rd1_ff;
   logic signed [VAL_W-1:0] ca_rd_ff, cb_rd_ff, da_rd_ff, db_rd_ff;

   logic [AW-1:0] ez_ra0, ez_ra1, hx_ra1, hy_ra1, cell_k;
   logic [AW-1:0] ez_wa, hx_wa, hy_wa;
   logic          ez_we, hx_we, hy_we, coef_we;
   logic signed [VAL_W-1:0] ez_wd, hx_wd, hy_wd;

   // Sequencer state
   back_state_type state_ff, state_in;
   item_type       cur_ff, cur_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [XW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [XW-1:0]  w_ff, w_in, h_ff, h_in, ce_ff, ce_in, re_ff, re_in;
   logic [XW-1:0]  w_c, h_c, ce_c, re_c, cf_x, rf_x;
   logic [AW-1:0]  item_k, sweep_k;
   logic signed [VAL_W-1:0] ez_r_ff, ez_r_in;

   // Products
   logic signed [PROD_W-1:0] pa_x_ff, pa_x_in, pb_x_ff, pb_x_in;
   logic signed [PROD_W-1:0] pa_y_ff, pa_y_in, pb_y_ff, pb_y_in;
   logic signed [VAL_W:0]    curl_x, curl_y;
   logic signed [VAL_W+2:0]  curl_e;
   logic signed [2*VAL_W-1:0] m_ax, m_ay, m_ae;
   logic signed [2*VAL_W:0]   m_bx, m_by;
   logic signed [2*VAL_W+2:0] m_be;

   // Result and output register
   logic signed [VAL_W-1:0] res_ez_ff, res_ez_in, res_hx_ff, res_hx_in, res_hy_ff, res_hy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic signed [VAL_W-1:0] rsp_ez_ff, rsp_ez_in, rsp_hx_ff, rsp_hx_in, rsp_hy_ff, rsp_hy_in;

   // Address and arithmetic helpers
   always_comb begin
      item_k  = AW'(int'(cur_ff.row) * MAX_COLS + int'(cur_ff.col));
      sweep_k = AW'(int'(j_ff) * MAX_COLS + int'(i_ff));
      cell_k  = (state_ff == ST_READ) ? item_k : sweep_k;
      ez_ra0  = cell_k;
      ez_ra1  = (state_ff == ST_H_DOWN) ? cell_k + AW'(MAX_COLS) : cell_k + AW'(1);
      hx_ra1  = cell_k - AW'(MAX_COLS);
      hy_ra1  = cell_k - AW'(1);

      cf_x = XW'(cfg.col_first);
      rf_x = XW'(cfg.row_first);
      w_c  = (XW'(cfg.grid_width) > XW'(MAX_COLS)) ? XW'(MAX_COLS) : XW'(cfg.grid_width);
      h_c  = (XW'(cfg.grid_height) > XW'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(cfg.grid_height);
      ce_c = (XW'(cfg.col_end) < w_c) ? XW'(cfg.col_end) : w_c;
      re_c = (XW'(cfg.row_end) < h_c) ? XW'(cfg.row_end) : h_c;

      curl_x = ez_rd0_ff - ez_rd1_ff;
      curl_y = ez_r_ff - ez_rd0_ff;
      curl_e = hy_rd0_ff - hy_rd1_ff - hx_rd0_ff + hx_rd1_ff;
      m_ax   = da_rd_ff * hx_rd0_ff;
      m_bx   = db_rd_ff * curl_x;
      m_ay   = da_rd_ff * hy_rd0_ff;
      m_by   = db_rd_ff * curl_y;
      m_ae   = ca_rd_ff * ez_rd0_ff;
      m_be   = cb_rd_ff * curl_e;
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      ce_in        = ce_ff;
      re_in        = re_ff;
      ez_r_in      = ez_r_ff;
      pa_x_in      = pa_x_ff;
      pb_x_in      = pb_x_ff;
      pa_y_in      = pa_y_ff;
      pb_y_in      = pb_y_ff;
      res_ez_in    = res_ez_ff;
      res_hx_in    = res_hx_ff;
      res_hy_in    = res_hy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ez_in    = rsp_ez_ff;
      rsp_hx_in    = rsp_hx_ff;
      rsp_hy_in    = rsp_hy_ff;
      q_pop        = 1'b0;
      ez_we        = 1'b0;
      hx_we        = 1'b0;
      hy_we        = 1'b0;
      coef_we      = 1'b0;
      ez_wa        = sweep_k;
      hx_wa        = sweep_k;
      hy_wa        = sweep_k;
      ez_wd        = combine(pa_x_ff, pb_x_ff);
      hx_wd        = combine(pa_x_ff, pb_x_ff);
      hy_wd        = combine(pa_y_ff, pb_y_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            ez_we = 1'b1;
            hx_we = 1'b1;
            hy_we = 1'b1;
            ez_wa = clr_ff;
            hx_wa = clr_ff;
            hy_wa = clr_ff;
            ez_wd = '0;
            hx_wd = '0;
            hy_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cur_in    = q_item;
               res_ez_in = '0;
               res_hx_in = '0;
               res_hy_in = '0;
               if (q_item.kind == KIND_WRITE) begin
                  state_in = ST_WRITE;
               end else if (q_item.kind == KIND_STEP) begin
                  state_in = ST_STEP_INIT;
               end else if (q_item.kind == KIND_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WRITE: begin
            ez_we   = cur_ff.in_grid;
            hx_we   = cur_ff.in_grid;
            hy_we   = cur_ff.in_grid;
            coef_we = cur_ff.in_grid;
            ez_wa   = item_k;
            hx_wa   = item_k;
            hy_wa   = item_k;
            ez_wd   = cur_ff.ez;
            hx_wd   = cur_ff.hx;
            hy_wd   = cur_ff.hy;
            state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            if (cur_ff.in_grid) begin
               res_ez_in = ez_rd0_ff;
               res_hx_in = hx_rd0_ff;
               res_hy_in = hy_rd0_ff;
            end
            state_in = ST_DONE;
         end
         ST_STEP_INIT: begin
            w_in  = w_c;
            h_in  = h_c;
            ce_in = ce_c;
            re_in = re_c;
            i_in  = cf_x;
            j_in  = rf_x;
            if ((cf_x < ce_c) && (rf_x < re_c)) begin
               state_in = ST_H_ADDR;
            end else begin
               state_in = ST_E_INIT;
            end
         end
         // H cell: read center and right neighbor, then the one below
         ST_H_ADDR: begin
            state_in = ST_H_DOWN;
         end
         ST_H_DOWN: begin
            ez_r_in  = ez_rd1_ff;
            state_in = ST_H_MUL;
         end
         ST_H_MUL: begin
            pa_x_in  = PROD_W'(m_ax);
            pb_x_in  = PROD_W'(m_bx);
            pa_y_in  = PROD_W'(m_ay);
            pb_y_in  = PROD_W'(m_by);
            state_in = ST_H_WB;
         end
         ST_H_WB: begin
            hx_we = (j_ff + XW'(1)) < h_ff;
            hy_we = (i_ff + XW'(1)) < w_ff;
            if ((i_ff + XW'(1)) < ce_ff) begin
               i_in     = i_ff + XW'(1);
               state_in = ST_H_ADDR;
            end else if ((j_ff + XW'(1)) < re_ff) begin
               i_in     = cf_x;
               j_in     = j_ff + XW'(1);
               state_in = ST_H_ADDR;
            end else begin
               state_in = ST_E_INIT;
            end
         end
         ST_E_INIT: begin
            i_in = cf_x + XW'(1);
            j_in = rf_x + XW'(1);
            if (((cf_x + XW'(2)) < ce_ff) && ((rf_x + XW'(2)) < re_ff)) begin
               state_in = ST_E_ADDR;
            end else begin
               state_in = ST_DONE;
            end
         end
         // E cell: center, left and upper neighbors in one read
         ST_E_ADDR: begin
            state_in = ST_E_MUL;
         end
         ST_E_MUL: begin
            pa_x_in  = PROD_W'(m_ae);
            pb_x_in  = PROD_W'(m_be);
            state_in = ST_E_WB;
         end
         ST_E_WB: begin
            ez_we = 1'b1;
            if ((i_ff + XW'(2)) < ce_ff) begin
               i_in     = i_ff + XW'(1);
               state_in = ST_E_ADDR;
            end else if ((j_ff + XW'(2)) < re_ff) begin
               i_in     = cf_x + XW'(1);
               j_in     = j_ff + XW'(1);
               state_in = ST_E_ADDR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cur_ff.kind;
               rsp_ez_in    = res_ez_ff;
               rsp_hx_in    = res_hx_ff;
               rsp_hy_in    = res_hy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      ce_ff       <= ce_in;
      re_ff       <= re_in;
      ez_r_ff     <= ez_r_in;
      pa_x_ff     <= pa_x_in;
      pb_x_ff     <= pb_x_in;
      pa_y_ff     <= pa_y_in;
      pb_y_ff     <= pb_y_in;
      res_ez_ff   <= res_ez_in;
      res_hx_ff   <= res_hx_in;
      res_hy_ff   <= res_hy_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ez_ff   <= rsp_ez_in;
      rsp_hx_ff   <= rsp_hx_in;
      rsp_hy_ff   <= rsp_hy_in;
   end

   // Field stores: one write and two registered reads each
   always_ff @(posedge clock) begin
      if (ez_we) begin
         ez_mem[ez_wa] <= ez_wd;
      end
      ez_rd0_ff <= ez_mem[ez_ra0];
      ez_rd1_ff <= ez_mem[ez_ra1];
   end

   always_ff @(posedge clock) begin
      if (hx_we) begin
         hx_mem[hx_wa] <= hx_wd;
      end
      hx_rd0_ff <= hx_mem[cell_k];
      hx_rd1_ff <= hx_mem[hx_ra1];
   end

   always_ff @(posedge clock) begin
      if (hy_we) begin
         hy_mem[hy_wa] <= hy_wd;
      end
      hy_rd0_ff <= hy_mem[cell_k];
      hy_rd1_ff <= hy_mem[hy_ra1];
   end

   // Coefficient stores: written only by write transactions
   always_ff @(posedge clock) begin
      if (coef_we) begin
         ca_mem[item_k] <= cur_ff.ca;
         cb_mem[item_k] <= cur_ff.cb;
         da_mem[item_k] <= cur_ff.da;
         db_mem[item_k] <= cur_ff.db;
      end
      ca_rd_ff <= ca_mem[cell_k];
      cb_rd_ff <= cb_mem[cell_k];
      da_rd_ff <= da_mem[cell_k];
      db_rd_ff <= db_mem[cell_k];
   end

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_ez_out     = rsp_ez_ff;
   assign rsp_hx_out     = rsp_hx_ff;
   assign rsp_hy_out     = rsp_hy_ff;

endmodule

>>> design/fdtd_chk.sv
// ----------------------------------------------------------------------------
// fdtd_chk
// Port-level checks of the Yee grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module fdtd_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fdtd_pkg::KIND_W-1:0]       rsp_reply_kind,
   input logic signed [fdtd_pkg::VAL_W-1:0] rsp_ez_out,
   input logic signed [fdtd_pkg::VAL_W-1:0] rsp_hx_out,
   input logic signed [fdtd_pkg::VAL_W-1:0] rsp_hy_out
);
   import fdtd_pkg::*;

   // Reset starts the clearing pass: no response and no request taken
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("response or ready right after reset");

   // Only read transactions carry field values
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_kind != KIND_READ) |->
      (rsp_ez_out == '0 && rsp_hx_out == '0 && rsp_hy_out == '0))
      else $error("non-read response with nonzero fields");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_reply_kind) && $stable(rsp_ez_out)
       && $stable(rsp_hx_out) && $stable(rsp_hy_out)))
      else $error("stalled response changed");

endmodule

bind fdtd_tm_yee_update fdtd_chk u_chk (.*);
